// File: rtl/wsdf_pkg.sv
`timescale 1ns / 1ps

package wsdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int USER_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 32;
    localparam int CNT_W    = 3;

    localparam logic [6:0]       LEN_EXT16     = 7'd126;
    localparam logic [6:0]       LEN_EXT64     = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_BYTES   = 3'd2;
    localparam logic [CNT_W-1:0] KEY_BYTES     = 3'd4;
    localparam logic [CNT_W-1:0] EXT64_WRAP    = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE       = 3'd1;

    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                empty;
        logic                fin;
        logic [OPCODE_W-1:0] opcode;
    } t_tag;

endpackage

// File: rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// websocket frame deframer
// slave channel takes the received stream one byte per transaction; master
// channel gives one transaction per payload byte, unmasked with the frame key,
// tagged with opcode and fin; tlast marks the last byte of a frame. a frame
// with no payload gives a single transaction with the empty flag set, tdata
// zero and tlast high, on the transaction of its last header byte. header,
// extended length and key bytes give no transaction otherwise.
// an accepted byte is held in the input register and is then parsed into the
// result register, from which the master channel gives its result.
// one byte per cycle, sustained while the receiver takes results; the parse
// state updates in the single logic stage between the two registers.
// reset (synchronous, active low) empties both registers and returns the
// parser to the first header byte of a new frame.
// when the receiver stalls, the result register holds, the input register
// keeps one more byte, and tready drops only once both are full.
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [USER_W-1:0] m_axis_tuser,   // [3:0] frame_opcode, [4] final_fragment,
                                              // [5] frame_empty, [7:6] zero
    output logic              m_axis_tlast    // frame_last
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    t_phase              r_phase, n_phase;
    logic                r_fin, n_fin;
    logic [OPCODE_W-1:0] r_opcode, n_opcode;
    logic                r_mask, n_mask;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEN_W-1:0]    r_key, n_key;
    logic [1:0]          r_pos, n_pos;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    t_tag              r_out_tag;
    logic              r_out_last;

    logic              adv;
    logic              fire;
    logic              emit;
    logic [BYTE_W-1:0] emit_data;
    logic              emit_last;
    logic              emit_empty;
    logic [CNT_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] key_byte;
    logic              len_done;
    logic [6:0]        len7;

    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;
    assign cnt_inc       = r_cnt + CNT_ONE;
    assign len7          = r_in_byte[6:0];

    always_comb begin
        unique case (r_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_key      = r_key;
        n_pos      = r_pos;
        emit       = 1'b0;
        emit_data  = '0;
        emit_last  = 1'b1;
        emit_empty = 1'b1;
        len_done   = 1'b0;
        unique case (r_phase)
            PH_HDR1: begin
                n_mask = r_in_byte[7];
                n_cnt  = '0;
                if (len7 == LEN_EXT16) begin
                    n_len   = '0;
                    n_phase = PH_EXT16;
                end else if (len7 == LEN_EXT64) begin
                    n_len   = '0;
                    n_phase = PH_EXT64;
                end else begin
                    n_len = {{(LEN_W-7){1'b0}}, len7};
                    if (r_in_byte[7]) begin
                        n_key   = '0;
                        n_phase = PH_MASK;
                    end else begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_EXT16: begin
                n_len = {{(LEN_W-16){1'b0}}, r_len[7:0], r_in_byte};
                n_cnt = cnt_inc;
                if (cnt_inc == EXT16_BYTES) begin
                    n_cnt = '0;
                    if (r_mask) begin
                        n_key   = '0;
                        n_phase = PH_MASK;
                    end else begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_EXT64: begin
                n_len = {r_len[LEN_W-9:0], r_in_byte};
                n_cnt = cnt_inc;
                if (cnt_inc == EXT64_WRAP) begin
                    if (r_mask) begin
                        n_key   = '0;
                        n_phase = PH_MASK;
                    end else begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_MASK: begin
                n_key = {r_key[LEN_W-9:0], r_in_byte};
                n_cnt = cnt_inc;
                if (cnt_inc == KEY_BYTES) begin
                    len_done = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                emit       = 1'b1;
                emit_empty = 1'b0;
                emit_data  = r_mask ? (r_in_byte ^ key_byte) : r_in_byte;
                emit_last  = (r_len == {{(LEN_W-1){1'b0}}, 1'b1});
                n_len      = r_len - {{(LEN_W-1){1'b0}}, 1'b1};
                n_pos      = r_pos + 2'd1;
                if (emit_last) begin
                    n_pos   = '0;
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin    = r_in_byte[7];
                n_opcode = r_in_byte[OPCODE_W-1:0];
                n_phase  = PH_HDR1;
            end
        endcase
        if (len_done) begin
            n_cnt = '0;
            n_pos = '0;
            if (n_len == '0) begin
                emit    = 1'b1;
                n_phase = PH_HDR0;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data       <= emit_data;
            r_out_last       <= emit_last;
            r_out_tag.empty  <= emit_empty;
            r_out_tag.fin    <= r_fin;
            r_out_tag.opcode <= r_opcode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {{(USER_W-$bits(t_tag)){1'b0}}, r_out_tag};

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_tag.empty |-> m_axis_tlast)
        else $error("empty marker without tlast");

    a_empty_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_tag.empty |-> m_axis_tdata == '0)
        else $error("empty marker with nonzero data");

    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_len != '0)
        else $error("payload phase with zero remaining length");

    a_key_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MASK |-> r_cnt < KEY_BYTES)
        else $error("key byte count out of range");

    a_no_output_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_phase == PH_HDR0 || r_phase == PH_EXT16 || r_phase == PH_EXT64)
            && !(r_phase == PH_EXT16 || r_phase == PH_EXT64) |=> !m_axis_tvalid)
        else $error("result on first header byte");

endmodule

// File: verif/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    typedef enum int {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } t_len_form;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_tag              tag;
        logic              last;
    } t_payload_beat;

    class deframer_scoreboard;
        t_payload_beat     expected_beats[$];
        int                errors;
        t_phase            phase;
        logic              fin;
        logic [OPCODE_W-1:0] opcode;
        logic              masked;
        logic [LEN_W-1:0]  length;
        logic [CNT_W-1:0]  hdr_cnt;
        logic [LEN_W-1:0]  key;
        logic [LEN_W-1:0]  pos;

        function new();
            errors  = 0;
            phase   = PH_HDR0;
            fin     = 1'b0;
            opcode  = '0;
            masked  = 1'b0;
            length  = '0;
            hdr_cnt = '0;
            key     = '0;
            pos     = '0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(logic [BYTE_W-1:0] data, logic last, logic empty);
            t_payload_beat beat;
            beat.data       = data;
            beat.tag.empty  = empty;
            beat.tag.fin    = fin;
            beat.tag.opcode = opcode;
            beat.last       = last;
            expected_beats.insert(expected_beats.size(), beat);
        endfunction

        function void length_complete();
            hdr_cnt = '0;
            pos     = '0;
            if (length == '0) begin
                push_beat('0, 1'b1, 1'b1);
                phase = PH_HDR0;
            end else begin
                phase = PH_PAYLOAD;
            end
        endfunction

        function void header_complete();
            if (masked) begin
                hdr_cnt = '0;
                key     = '0;
                phase   = PH_MASK;
            end else begin
                length_complete();
            end
        endfunction

        // one accepted rx byte through the parser
        function void take_rx_byte(logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] key_byte;
            logic              last;
            case (phase)
                PH_HDR1: begin
                    masked  = b[7];
                    hdr_cnt = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        length = '0;
                        phase  = PH_EXT16;
                    end else if (b[6:0] == LEN_EXT64) begin
                        length = '0;
                        phase  = PH_EXT64;
                    end else begin
                        length = {25'd0, b[6:0]};
                        header_complete();
                    end
                end
                PH_EXT16: begin
                    length  = {16'd0, length[7:0], b};
                    hdr_cnt = hdr_cnt + CNT_ONE;
                    if (hdr_cnt == EXT16_BYTES)
                        header_complete();
                end
                PH_EXT64: begin
                    length  = {length[23:0], b};
                    hdr_cnt = hdr_cnt + CNT_ONE;
                    if (hdr_cnt == EXT64_WRAP)
                        header_complete();
                end
                PH_MASK: begin
                    key     = {key[23:0], b};
                    hdr_cnt = hdr_cnt + CNT_ONE;
                    if (hdr_cnt == KEY_BYTES)
                        length_complete();
                end
                PH_PAYLOAD: begin
                    key_byte = masked ? key[8*(3 - pos[1:0]) +: 8] : '0;
                    last     = (pos == length - 32'd1);
                    push_beat(b ^ key_byte, last, 1'b0);
                    pos = pos + 32'd1;
                    if (last) begin
                        pos   = '0;
                        phase = PH_HDR0;
                    end
                end
                default: begin
                    fin    = b[7];
                    opcode = b[3:0];
                    phase  = PH_HDR1;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_beat(logic [BYTE_W-1:0] data, logic [USER_W-1:0] user,
                                 logic last);
            t_payload_beat want;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: expected none, actual %0h %0h %0b",
                         $time, data, user, last);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("payload_byte", 32'(want.data), 32'(data));
            compare_field("frame_opcode", 32'(want.tag.opcode), 32'(user[3:0]));
            compare_field("final_fragment", 32'(want.tag.fin), 32'(user[4]));
            compare_field("frame_empty", 32'(want.tag.empty), 32'(user[5]));
            compare_field("tuser_reserved", 32'd0, 32'(user[7:6]));
            compare_field("frame_last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    logic              m_axis_tlast;

    deframer_scoreboard sb = new();
    int send_idle;
    int recv_idle;
    int bytes_sent;

    websocket_frame_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_rx_byte(value);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] hdr0, input t_len_form form,
                              input logic [31:0] len, input logic masked,
                              input logic [31:0] key, input logic [31:0] hi_word);
        send_byte(hdr0);
        case (form)
            FORM_EXT16: begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            FORM_EXT64: begin
                send_byte({masked, LEN_EXT64});
                for (int i = 3; i >= 0; i--) send_byte(hi_word[8*i +: 8]);
                for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
            default: begin
                send_byte({masked, len[6:0]});
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        for (int i = 0; i < len; i++) send_byte(8'($urandom()));
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [31:0] len;
        t_len_form   form;
        pick = $urandom_range(99);
        if (pick < 70) begin
            form = FORM_SHORT;
            if ($urandom_range(19) == 0)
                len = $urandom_range(1) ? 125 : $urandom_range(100, 124);
            else
                len = $urandom_range(0, 12);
        end else if (pick < 88) begin
            form = FORM_EXT16;
            len  = ($urandom_range(9) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 20);
        end else begin
            form = FORM_EXT64;
            len  = $urandom_range(0, 20);
        end
        send_frame(8'($urandom()), form, len, 1'($urandom_range(1)), $urandom(), $urandom());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        bytes_sent    = 0;
        send_idle     = 32;
        recv_idle     = 58;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty frames: short, masked, zero extended length
        send_frame(8'h81, FORM_SHORT, 0, 1'b0, '0, '0);
        send_frame(8'h7F, FORM_SHORT, 0, 1'b1, 32'hFFFF_FFFF, '0);
        send_frame(8'h00, FORM_EXT16, 0, 1'b0, '0, '0);
        // 64-bit length with upper word dropped
        send_frame(8'h8A, FORM_EXT64, 1, 1'b0, '0, 32'hFFFF_FFFF);
        // key wraps over payload positions
        send_frame(8'hF2, FORM_SHORT, 5, 1'b1, 32'hA5C3_0FF0, '0);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 32; recv_idle = 58; end
                1: begin send_idle = 58; recv_idle = 32; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            while (bytes_sent < (ph + 1) * 217) send_random_frame();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wsdf_pkg.sv
rtl/websocket_frame_deframer.sv
verif/tb_websocket_frame_deframer.sv
